### design/mabf_pkg.sv
// Shared types, constants and the sine/cosine table of the minimum-area yaw box fit.
// Used by mabf_ctrl, mabf_datapath and min_area_yaw_box_fit; depends on nothing.
package mabf_pkg;

   localparam int MAX_POINTS  = 1024;
   localparam int ANGLE_STEPS = 361;
   localparam int COORD_BITS  = 16;

   localparam int ADDR_BITS    = $clog2(MAX_POINTS);
   localparam int CNT_BITS     = ADDR_BITS + 1;
   localparam int SUM_BITS     = COORD_BITS + ADDR_BITS + 1;
   localparam int MAG_BITS     = SUM_BITS - 1;
   localparam int DIV_CNT_BITS = $clog2(MAG_BITS + 2);
   localparam int STEP_BITS    = $clog2(ANGLE_STEPS);
   localparam int TRIG_BITS    = 16;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = TRIG_BITS + DIFF_BITS;
   localparam int ROT_BITS     = PROD_BITS + 1;
   localparam int SPAN_BITS    = ROT_BITS + 1;
   localparam int MID_BITS     = TRIG_BITS + ROT_BITS;
   localparam int EXT_BITS     = 16;
   localparam int AREA_BITS    = 2 * EXT_BITS;
   localparam int YAW_BITS     = 9;

   localparam longint unsigned PI_Q30 = 64'd3373259426;

   typedef logic [2*TRIG_BITS-1:0] trig_rom_type [ANGLE_STEPS];

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_TRIG,
      ST_SCAN,
      ST_DRAIN,
      ST_EXTENT,
      ST_MULT,
      ST_CMP,
      ST_RESULT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                 load;
      logic                 div_start;
      logic                 trig_load;
      logic                 issue;
      logic                 first;
      logic [ADDR_BITS-1:0] idx;
      logic [STEP_BITS-1:0] step;
      logic                 extent;
      logic                 mult;
      logic                 cmp;
      logic                 result_load;
   } cmd_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] count;
      logic                div_busy;
      logic                pipe_busy;
   } status_type;

   function automatic longint q15_of_q30(longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r < 0) r = 0;
      if (r > 32767) r = 32767;
      return r;
   endfunction

   function automatic trig_rom_type build_trig_rom();
      trig_rom_type    rom;
      longint unsigned th;
      longint unsigned xa;
      longint unsigned ts;
      longint unsigned tc;
      longint          ss;
      longint          sc;
      longint          sq;
      longint          cq;
      bit              folded;
      for (int k = 0; k < ANGLE_STEPS; k++) begin
         th = (64'(k) * PI_Q30) / 64'(ANGLE_STEPS - 1);
         if (th > PI_Q30) th = PI_Q30;
         folded = (th > PI_Q30 / 2);
         xa = folded ? (PI_Q30 - th) : th;
         ts = xa;
         ss = longint'(xa);
         tc = 64'd1 << 30;
         sc = longint'(tc);
         for (int n = 1; n <= 7; n++) begin
            ts = (ts * xa) >> 30;
            ts = ((ts * xa) >> 30) / 64'((2 * n) * (2 * n + 1));
            tc = (tc * xa) >> 30;
            tc = ((tc * xa) >> 30) / 64'((2 * n - 1) * (2 * n));
            if ((n % 2) == 1) begin
               ss = ss - longint'(ts);
               sc = sc - longint'(tc);
            end else begin
               ss = ss + longint'(ts);
               sc = sc + longint'(tc);
            end
         end
         sq = q15_of_q30(ss);
         cq = q15_of_q30(sc);
         if (folded) cq = -cq;
         rom[k] = {TRIG_BITS'(sq), TRIG_BITS'(cq)};
      end
      return rom;
   endfunction

   localparam trig_rom_type TRIG_ROM = build_trig_rom();

endpackage

### design/mabf_ctrl.sv
// Sequencer of the yaw box fit: point loading, centroid division, angle sweep, result.
// Depends on mabf_pkg; drives mabf_datapath through cmd_type and reads status_type.
module mabf_ctrl
   import mabf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type            state_ff, state_in;
   logic [ADDR_BITS-1:0] idx_ff, idx_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [ADDR_BITS-1:0] last_idx;
   logic                 scan_end;
   logic                 step_end;

   assign last_idx = ADDR_BITS'(status.count - CNT_BITS'(1));
   assign scan_end = (idx_ff == last_idx);
   assign step_end = (step_ff == STEP_BITS'(ANGLE_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tlast) state_in = ST_START;
         end
         ST_START: begin
            if (status.count == '0) state_in = ST_RESULT;
            else                    state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!status.div_busy) state_in = ST_TRIG;
         end
         ST_TRIG:   state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_end) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) state_in = ST_EXTENT;
         end
         ST_EXTENT: state_in = ST_MULT;
         ST_MULT:   state_in = ST_CMP;
         ST_CMP: begin
            if (step_end) state_in = ST_RESULT;
            else          state_in = ST_TRIG;
         end
         ST_RESULT: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in  = idx_ff;
      step_in = step_ff;
      unique case (state_ff)
         ST_START: step_in = '0;
         ST_TRIG:  idx_in  = '0;
         ST_SCAN:  idx_in  = idx_ff + ADDR_BITS'(1);
         ST_CMP:   step_in = step_ff + STEP_BITS'(1);
         default: begin
         end
      endcase
   end

   always_comb begin
      req_tready      = (state_ff == ST_IDLE);
      rsp_tvalid      = (state_ff == ST_OUT);
      cmd             = '0;
      cmd.load        = (state_ff == ST_IDLE) && req_tvalid;
      cmd.div_start   = (state_ff == ST_START) && (status.count != '0);
      cmd.trig_load   = (state_ff == ST_TRIG);
      cmd.issue       = (state_ff == ST_SCAN);
      cmd.first       = (idx_ff == '0);
      cmd.idx         = idx_ff;
      cmd.step        = step_ff;
      cmd.extent      = (state_ff == ST_EXTENT);
      cmd.mult        = (state_ff == ST_MULT);
      cmd.cmp         = (state_ff == ST_CMP);
      cmd.result_load = (state_ff == ST_RESULT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
      end
   end

endmodule

### design/mabf_datapath.sv
// Datapath of the yaw box fit: point store, sums, centroid divider, rotation pipeline,
// extent and area logic and the result registers. Depends on mabf_pkg.
module mabf_datapath
   import mabf_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   input  logic signed [COORD_BITS-1:0] x_mm,
   input  logic signed [COORD_BITS-1:0] y_mm,
   input  logic signed [COORD_BITS-1:0] z_mm,
   output status_type                   status,
   output logic signed [15:0]           center_x,
   output logic signed [15:0]           center_y,
   output logic signed [15:0]           mid_z,
   output logic [YAW_BITS-1:0]          yaw_step,
   output logic [EXT_BITS-1:0]          box_width,
   output logic [EXT_BITS-1:0]          box_depth,
   output logic [EXT_BITS-1:0]          box_height,
   output logic                         empty_cloud,
   output logic                         truncated
);

   function automatic logic signed [15:0] sat16(input logic signed [MID_BITS:0] v);
      logic signed [15:0] r;
      if (v > (MID_BITS+1)'(32767))       r = 16'sd32767;
      else if (v < -(MID_BITS+1)'(32768)) r = -16'sd32768;
      else                                r = 16'(v);
      return r;
   endfunction

   logic [2*COORD_BITS-1:0]      store [MAX_POINTS];
   logic [2*COORD_BITS-1:0]      rd_ff;
   logic [CNT_BITS-1:0]          count_ff;
   logic signed [SUM_BITS-1:0]   sum_ff [2];
   logic signed [COORD_BITS-1:0] zlo_ff, zhi_ff;
   logic                         ovf_ff;
   logic                         full;
   logic                         wr_en;

   logic [MAG_BITS-1:0]          mag_ff [2];
   logic [CNT_BITS-1:0]          rem_ff [2];
   logic                         neg_ff [2];
   logic signed [COORD_BITS-1:0] cen_ff [2];
   logic [DIV_CNT_BITS-1:0]      div_cnt_ff;
   logic                         div_busy_ff;
   logic [CNT_BITS:0]            trial [2];
   logic                         ge [2];
   logic [SUM_BITS-1:0]          abs_sum [2];
   logic [SUM_BITS-1:0]          quo_adj [2];

   logic signed [TRIG_BITS-1:0]  sin_ff, cos_ff;
   logic [3:0]                   pv_ff;
   logic [3:0]                   pf_ff;
   logic signed [DIFF_BITS-1:0]  dx_ff, dy_ff;
   logic signed [PROD_BITS-1:0]  cdx_ff, sdy_ff, cdy_ff, sdx_ff;
   logic signed [ROT_BITS-1:0]   u_ff, v_ff;
   logic signed [ROT_BITS-1:0]   umin_ff, umax_ff, vmin_ff, vmax_ff;

   logic signed [SPAN_BITS-1:0]  uspan, vspan, usum, vsum;
   logic signed [SPAN_BITS-1:0]  wround, dround;
   logic [EXT_BITS-1:0]          w_ff, d_ff;
   logic signed [ROT_BITS-1:0]   mu_ff, mv_ff;
   logic [AREA_BITS-1:0]         area_ff;
   logic signed [MID_BITS-1:0]   cmu_ff, smv_ff, smu_ff, cmv_ff;
   logic signed [MID_BITS:0]     bxq, byq;

   logic [AREA_BITS-1:0]         low_area_ff;
   logic [STEP_BITS-1:0]         best_step_ff;
   logic [EXT_BITS-1:0]          bw_ff, bd_ff;
   logic signed [15:0]           bx_ff, by_ff;
   logic signed [COORD_BITS:0]   zmid;

   assign full  = (count_ff == CNT_BITS'(MAX_POINTS));
   assign wr_en = cmd.load && !full;

   always_ff @(posedge clock) begin
      if (wr_en) store[count_ff[ADDR_BITS-1:0]] <= {y_mm, x_mm};
      if (cmd.issue) rd_ff <= store[cmd.idx];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.result_load) begin
         count_ff  <= '0;
         sum_ff[0] <= '0;
         sum_ff[1] <= '0;
         zlo_ff    <= {1'b0, {(COORD_BITS-1){1'b1}}};
         zhi_ff    <= {1'b1, {(COORD_BITS-1){1'b0}}};
         ovf_ff    <= 1'b0;
      end else if (cmd.load) begin
         if (full) begin
            ovf_ff <= 1'b1;
         end else begin
            count_ff  <= count_ff + CNT_BITS'(1);
            sum_ff[0] <= sum_ff[0] + SUM_BITS'(x_mm);
            sum_ff[1] <= sum_ff[1] + SUM_BITS'(y_mm);
            if (z_mm < zlo_ff) zlo_ff <= z_mm;
            if (z_mm > zhi_ff) zhi_ff <= z_mm;
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         trial[a]   = {rem_ff[a], mag_ff[a][MAG_BITS-1]};
         ge[a]      = (trial[a] >= {1'b0, count_ff});
         abs_sum[a] = sum_ff[a][SUM_BITS-1] ? SUM_BITS'(-sum_ff[a]) : SUM_BITS'(sum_ff[a]);
         quo_adj[a] = SUM_BITS'(mag_ff[a]) + SUM_BITS'(rem_ff[a] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= DIV_CNT_BITS'(MAG_BITS);
      end else if (div_busy_ff) begin
         if (div_cnt_ff == '0) div_busy_ff <= 1'b0;
         else                  div_cnt_ff  <= div_cnt_ff - DIV_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 2; a++) begin
         if (cmd.div_start) begin
            neg_ff[a] <= sum_ff[a][SUM_BITS-1];
            mag_ff[a] <= abs_sum[a][MAG_BITS-1:0];
            rem_ff[a] <= '0;
         end else if (div_busy_ff) begin
            if (div_cnt_ff != '0) begin
               rem_ff[a] <= ge[a] ? CNT_BITS'(trial[a] - {1'b0, count_ff})
                                  : CNT_BITS'(trial[a]);
               mag_ff[a] <= {mag_ff[a][MAG_BITS-2:0], ge[a]};
            end else begin
               cen_ff[a] <= neg_ff[a] ? COORD_BITS'(-quo_adj[a])
                                      : COORD_BITS'(mag_ff[a]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.trig_load) begin
         sin_ff <= TRIG_ROM[cmd.step][2*TRIG_BITS-1:TRIG_BITS];
         cos_ff <= TRIG_ROM[cmd.step][TRIG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else begin
         pv_ff <= {pv_ff[2:0], cmd.issue};
      end
      pf_ff <= {pf_ff[2:0], cmd.first};
   end

   always_ff @(posedge clock) begin
      dx_ff  <= DIFF_BITS'($signed(rd_ff[COORD_BITS-1:0])) - DIFF_BITS'(cen_ff[0]);
      dy_ff  <= DIFF_BITS'($signed(rd_ff[2*COORD_BITS-1:COORD_BITS])) - DIFF_BITS'(cen_ff[1]);
      cdx_ff <= cos_ff * dx_ff;
      sdy_ff <= sin_ff * dy_ff;
      cdy_ff <= cos_ff * dy_ff;
      sdx_ff <= sin_ff * dx_ff;
      u_ff   <= ROT_BITS'(cdx_ff) + ROT_BITS'(sdy_ff);
      v_ff   <= ROT_BITS'(cdy_ff) - ROT_BITS'(sdx_ff);
      if (pv_ff[3]) begin
         if (pf_ff[3] || (u_ff < umin_ff)) umin_ff <= u_ff;
         if (pf_ff[3] || (u_ff > umax_ff)) umax_ff <= u_ff;
         if (pf_ff[3] || (v_ff < vmin_ff)) vmin_ff <= v_ff;
         if (pf_ff[3] || (v_ff > vmax_ff)) vmax_ff <= v_ff;
      end
   end

   assign uspan  = SPAN_BITS'(umax_ff) - SPAN_BITS'(umin_ff);
   assign vspan  = SPAN_BITS'(vmax_ff) - SPAN_BITS'(vmin_ff);
   assign usum   = SPAN_BITS'(umax_ff) + SPAN_BITS'(umin_ff);
   assign vsum   = SPAN_BITS'(vmax_ff) + SPAN_BITS'(vmin_ff);
   assign wround = (uspan + SPAN_BITS'(16384)) >>> 15;
   assign dround = (vspan + SPAN_BITS'(16384)) >>> 15;

   always_ff @(posedge clock) begin
      if (cmd.extent) begin
         w_ff  <= (wround > SPAN_BITS'(65535)) ? {EXT_BITS{1'b1}} : EXT_BITS'(wround);
         d_ff  <= (dround > SPAN_BITS'(65535)) ? {EXT_BITS{1'b1}} : EXT_BITS'(dround);
         mu_ff <= ROT_BITS'(usum >>> 1);
         mv_ff <= ROT_BITS'(vsum >>> 1);
      end
      if (cmd.mult) begin
         area_ff <= w_ff * d_ff;
         cmu_ff  <= cos_ff * mu_ff;
         smv_ff  <= sin_ff * mv_ff;
         smu_ff  <= sin_ff * mu_ff;
         cmv_ff  <= cos_ff * mv_ff;
      end
   end

   assign bxq = ((((MID_BITS+1)'(cmu_ff) - (MID_BITS+1)'(smv_ff)
                  + (MID_BITS+1)'(1 << 29)) >>> 30) + (MID_BITS+1)'(cen_ff[0]));
   assign byq = ((((MID_BITS+1)'(smu_ff) + (MID_BITS+1)'(cmv_ff)
                  + (MID_BITS+1)'(1 << 29)) >>> 30) + (MID_BITS+1)'(cen_ff[1]));

   always_ff @(posedge clock) begin
      if (reset || cmd.result_load) begin
         low_area_ff  <= '1;
         best_step_ff <= '0;
      end else if (cmd.cmp && (area_ff < low_area_ff)) begin
         low_area_ff  <= area_ff;
         best_step_ff <= cmd.step;
      end
      if (cmd.cmp && (area_ff < low_area_ff)) begin
         bw_ff <= w_ff;
         bd_ff <= d_ff;
         bx_ff <= sat16(bxq);
         by_ff <= sat16(byq);
      end
   end

   assign zmid = ((COORD_BITS+1)'(zlo_ff) + (COORD_BITS+1)'(zhi_ff)) >>> 1;

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         truncated <= ovf_ff;
         if (count_ff == '0) begin
            empty_cloud <= 1'b1;
            center_x    <= '0;
            center_y    <= '0;
            mid_z       <= '0;
            yaw_step    <= '0;
            box_width   <= '0;
            box_depth   <= '0;
            box_height  <= '0;
         end else begin
            empty_cloud <= 1'b0;
            center_x    <= bx_ff;
            center_y    <= by_ff;
            mid_z       <= 16'(zmid);
            yaw_step    <= YAW_BITS'(best_step_ff);
            box_width   <= bw_ff;
            box_depth   <= bd_ff;
            box_height  <= 16'(zhi_ff - zlo_ff);
         end
      end
   end

   assign status.count     = count_ff;
   assign status.div_busy  = div_busy_ff;
   assign status.pipe_busy = |pv_ff;

endmodule

### design/min_area_yaw_box_fit.sv
// Top level of the minimum-area yaw box fit: stream ports, sequencer and datapath.
// Depends on mabf_pkg, mabf_ctrl and mabf_datapath.
//
// Points stream in one transaction per cycle; each stores its x,y (up to 1024 points,
// later ones are dropped and flagged) and updates the sums and the z range. The
// transaction with tlast set starts the fit: a bit-serial centroid division, then for
// each of the 361 yaw steps a table read, one point-store read per stored point, a
// pipeline drain, extent, multiply and compare. The point store has a single read
// port. No points are taken while the fit runs or while the result transaction
// waits.
module min_area_yaw_box_fit
   import mabf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,  // x_mm, y_mm, z_mm
   input  logic         req_tlast,  // last_point
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,  // center_x, center_y, center z, yaw_step,
                                    // box_width, box_depth, box_height, zero fill
   output logic [1:0]   rsp_tuser   // empty_cloud, truncated
);

   cmd_type            cmd;
   status_type         status;
   logic signed [15:0] center_x, center_y, mid_z;
   logic [8:0]         yaw_step;
   logic [15:0]        box_width, box_depth, box_height;
   logic               empty_cloud, truncated;

   mabf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mabf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .x_mm        (req_tdata[15:0]),
      .y_mm        (req_tdata[31:16]),
      .z_mm        (req_tdata[47:32]),
      .status      (status),
      .center_x    (center_x),
      .center_y    (center_y),
      .mid_z       (mid_z),
      .yaw_step    (yaw_step),
      .box_width   (box_width),
      .box_depth   (box_depth),
      .box_height  (box_height),
      .empty_cloud (empty_cloud),
      .truncated   (truncated)
   );

   assign rsp_tdata = {7'd0, box_height, box_depth, box_width, yaw_step,
                       mid_z, center_y, center_x};
   assign rsp_tuser = {truncated, empty_cloud};

endmodule

### tb/tb_top.sv
// Self-checking testbench of min_area_yaw_box_fit: point clouds go in as stream transactions
// and every box result is checked against a predictor of the yaw search kept in this file
// or the typed box of a directed row. Depends on mabf_pkg and min_area_yaw_box_fit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mabf_pkg::*;

   localparam int  STORE_DEPTH = 1024;
   localparam int  YAW_COUNT   = 361;
   localparam int  STALL_LIMIT = 1500000;
   localparam longint unsigned PI_FIXED = 64'd3373259426;

   typedef struct {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] cz;
      logic [8:0]         yaw;
      logic [15:0]        width;
      logic [15:0]        depth;
      logic [15:0]        height;
      logic               empty;
      logic               trunc;
   } box_type;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               last;
      bit                 typed;
      box_type            box;
   } point_row_type;

   localparam box_type NO_BOX = '{16'sd0, 16'sd0, 16'sd0, 9'd0, 16'd0, 16'd0, 16'd0,
                                  1'b0, 1'b0};

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [47:0]  req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   min_area_yaw_box_fit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // Predictor state of the point cloud.
   longint  cloud_x [STORE_DEPTH];
   longint  cloud_y [STORE_DEPTH];
   int      cloud_count;
   longint  cloud_sum_x;
   longint  cloud_sum_y;
   longint  cloud_z_low;
   longint  cloud_z_high;
   bit      cloud_dropped;
   longint  sine_q15 [YAW_COUNT];
   longint  cosine_q15 [YAW_COUNT];

   box_type pending_boxes [$];
   int      fail_count;
   int      idle_pct;
   int      stall_pct;
   int      quiet_cycles;
   int      items_sent;

   point_row_type directed [18] = '{
      '{16'sd100, -16'sd200, 16'sd5, 1'b1, 1'b1,
        '{16'sd100, -16'sd200, 16'sd5, 9'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 1'b1,
        '{-16'sd32768, -16'sd32768, -16'sd32768, 9'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b1,
        '{16'sd32767, 16'sd32767, 16'sd32767, 9'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{16'sd0, 16'sd0, -16'sd32768, 1'b0, 1'b0, NO_BOX},
      '{16'sd0, 16'sd0, 16'sd32767, 1'b1, 1'b1,
        '{16'sd0, 16'sd0, -16'sd1, 9'd0, 16'd0, 16'd0, 16'd65535, 1'b0, 1'b0}},
      '{-16'sd32768, -16'sd32768, 16'sd0, 1'b0, 1'b0, NO_BOX},
      '{16'sd32767, 16'sd32767, 16'sd1, 1'b0, 1'b0, NO_BOX},
      '{-16'sd32768, 16'sd32767, 16'sd2, 1'b0, 1'b0, NO_BOX},
      '{16'sd32767, -16'sd32768, 16'sd3, 1'b1, 1'b0, NO_BOX},
      '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, NO_BOX},
      '{16'sd1000, 16'sd0, 16'sd0, 1'b0, 1'b0, NO_BOX},
      '{16'sd2000, 16'sd10, 16'sd0, 1'b1, 1'b0, NO_BOX},
      '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, NO_BOX},
      '{16'sd100, 16'sd100, 16'sd0, 1'b0, 1'b0, NO_BOX},
      '{-16'sd50, 16'sd50, -16'sd1, 1'b0, 1'b0, NO_BOX},
      '{16'sd50, 16'sd150, 16'sd1, 1'b1, 1'b0, NO_BOX},
      '{16'sd7, 16'sd7, 16'sd7, 1'b0, 1'b0, NO_BOX},
      '{16'sd7, 16'sd7, 16'sd7, 1'b1, 1'b1,
        '{16'sd7, 16'sd7, 16'sd7, 9'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0}}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint floor_divide(longint num, longint den);
      if (num >= 0) return num / den;
      return -(((-num) - 1) / den) - 1;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint round_to_q15(longint v);
      return clamp((v + 64'sd16384) >>> 15, 0, 32767);
   endfunction

   function automatic void build_yaw_trig();
      longint unsigned angle, folded_angle, sin_term, cos_term;
      longint          sin_sum, cos_sum;
      bit              mirrored;
      for (int k = 0; k < YAW_COUNT; k++) begin
         angle = (64'(k) * PI_FIXED) / 64'(YAW_COUNT - 1);
         if (angle > PI_FIXED) angle = PI_FIXED;
         mirrored = angle > PI_FIXED / 2;
         folded_angle = mirrored ? PI_FIXED - angle : angle;
         sin_term = folded_angle;
         sin_sum = longint'(folded_angle);
         cos_term = 64'd1 << 30;
         cos_sum = longint'(cos_term);
         for (int n = 1; n <= 7; n++) begin
            sin_term = (sin_term * folded_angle) >> 30;
            sin_term = ((sin_term * folded_angle) >> 30) / 64'((2 * n) * (2 * n + 1));
            cos_term = (cos_term * folded_angle) >> 30;
            cos_term = ((cos_term * folded_angle) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
               sin_sum -= longint'(sin_term);
               cos_sum -= longint'(cos_term);
            end else begin
               sin_sum += longint'(sin_term);
               cos_sum += longint'(cos_term);
            end
         end
         sine_q15[k] = round_to_q15(sin_sum);
         cosine_q15[k] = mirrored ? -round_to_q15(cos_sum) : round_to_q15(cos_sum);
      end
   endfunction

   function automatic void clear_cloud();
      cloud_count = 0;
      cloud_sum_x = 0;
      cloud_sum_y = 0;
      cloud_z_low = 32767;
      cloud_z_high = -32768;
      cloud_dropped = 1'b0;
   endfunction

   function automatic longint span_mm(longint lo, longint hi);
      return clamp((hi - lo + 64'sd16384) >>> 15, 0, 65535);
   endfunction

   // Takes one point into the predicted cloud; returns 1 with the box when it closes the cloud.
   function automatic bit fit_point(logic signed [15:0] x, logic signed [15:0] y,
                                    logic signed [15:0] z, logic last, output box_type box);
      longint cen_x, cen_y, s, c, dx, dy, u, v, umin, umax, vmin, vmax, w, d;
      longint mid_u, mid_v, best_x, best_y, best_w, best_d;
      longint unsigned area, lowest_area;
      int best_k;
      box = NO_BOX;
      if (cloud_count < STORE_DEPTH) begin
         cloud_x[cloud_count] = x;
         cloud_y[cloud_count] = y;
         cloud_count++;
         cloud_sum_x += x;
         cloud_sum_y += y;
         if (z < cloud_z_low) cloud_z_low = z;
         if (z > cloud_z_high) cloud_z_high = z;
      end else begin
         cloud_dropped = 1'b1;
      end
      if (!last) return 0;
      box.trunc = cloud_dropped;
      if (cloud_count == 0) begin
         box.empty = 1'b1;
         clear_cloud();
         return 1;
      end
      cen_x = floor_divide(cloud_sum_x, cloud_count);
      cen_y = floor_divide(cloud_sum_y, cloud_count);
      lowest_area = 64'hFFFF_FFFF;
      best_k = 0; best_x = 0; best_y = 0; best_w = 0; best_d = 0;
      for (int k = 0; k < YAW_COUNT; k++) begin
         s = sine_q15[k];
         c = cosine_q15[k];
         for (int i = 0; i < cloud_count; i++) begin
            dx = cloud_x[i] - cen_x;
            dy = cloud_y[i] - cen_y;
            u = c * dx + s * dy;
            v = c * dy - s * dx;
            if (i == 0 || u < umin) umin = u;
            if (i == 0 || u > umax) umax = u;
            if (i == 0 || v < vmin) vmin = v;
            if (i == 0 || v > vmax) vmax = v;
         end
         w = span_mm(umin, umax);
         d = span_mm(vmin, vmax);
         area = w * d;
         if (area < lowest_area) begin
            mid_u = (umin + umax) >>> 1;
            mid_v = (vmin + vmax) >>> 1;
            lowest_area = area;
            best_k = k;
            best_w = w;
            best_d = d;
            best_x = ((c * mid_u - s * mid_v + 64'sd536870912) >>> 30) + cen_x;
            best_y = ((s * mid_u + c * mid_v + 64'sd536870912) >>> 30) + cen_y;
         end
      end
      box.cx = 16'(clamp(best_x, -32768, 32767));
      box.cy = 16'(clamp(best_y, -32768, 32767));
      box.cz = 16'(clamp((cloud_z_low + cloud_z_high) >>> 1, -32768, 32767));
      box.yaw = best_k[8:0];
      box.width = best_w[15:0];
      box.depth = best_d[15:0];
      box.height = 16'(cloud_z_high - cloud_z_low);
      clear_cloud();
      return 1;
   endfunction

   task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic last, bit typed, box_type typed_box);
      box_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (fit_point(x, y, z, last, predicted))
         pending_boxes.insert(pending_boxes.size(), typed ? typed_box : predicted);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_boxes.size() != 0) @(posedge clock);
   endtask

   // A cloud of 1..max_size+1 random points; the spread is sometimes full range, sometimes local.
   task automatic send_cloud(int max_size);
      int size, spread;
      logic signed [15:0] base_x, base_y;
      size = ($urandom_range(9) == 0) ? $urandom_range(max_size) + 1 : $urandom_range(5) + 1;
      spread = $urandom_range(3);
      base_x = 16'($urandom);
      base_y = 16'($urandom);
      for (int i = 0; i < size; i++) begin
         if (spread == 0)
            send_point(16'($urandom), 16'($urandom), 16'($urandom), i == size - 1,
                       1'b0, NO_BOX);
         else
            send_point(base_x + $signed(16'($urandom_range(64 << (4 * spread))) ),
                       base_y + $signed(16'($urandom_range(64 << (4 * spread)))),
                       16'($urandom), i == size - 1, 1'b0, NO_BOX);
      end
   endtask

   function automatic void check_field(string name, longint expected, longint actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      box_type box;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_boxes.size() == 0) begin
            $display("%0t: unexpected result transaction %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            box = pending_boxes.pop_front();
            check_field("center_x", box.cx, $signed(rsp_tdata[15:0]));
            check_field("center_y", box.cy, $signed(rsp_tdata[31:16]));
            check_field("z_mid", box.cz, $signed(rsp_tdata[47:32]));
            check_field("yaw_step", box.yaw, rsp_tdata[56:48]);
            check_field("box_width", box.width, rsp_tdata[72:57]);
            check_field("box_depth", box.depth, rsp_tdata[88:73]);
            check_field("box_height", box.height, rsp_tdata[104:89]);
            check_field("zero_fill", 0, rsp_tdata[111:105]);
            check_field("empty_cloud", box.empty, rsp_tuser[0]);
            check_field("truncated", box.trunc, rsp_tuser[1]);
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int random_base;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      fail_count = 0;
      idle_pct = 0;
      stall_pct = 0;
      quiet_cycles = 0;
      items_sent = 0;
      build_yaw_trig();
      clear_cloud();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_point(directed[i].x, directed[i].y, directed[i].z, directed[i].last,
                    directed[i].typed, directed[i].box);

      // Store full: one point beyond capacity, and it is the closing point.
      for (int i = 0; i < STORE_DEPTH + 1; i++)
         send_point($signed(16'($urandom_range(4000))) - 16'sd2000,
                    $signed(16'($urandom_range(1000))), 16'($urandom),
                    i == STORE_DEPTH, 1'b0, NO_BOX);
      wait_drained();

      random_base = items_sent;
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 85 : 20) : 0;
         stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 85 : 20) : 0;
         while (items_sent < random_base + 40 * (phase + 1)) begin
            send_cloud(16);
            if ($urandom_range(15) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_boxes.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
